@@ rtl/brsr_pkg.sv @@
// Shared types and constants for the bipolar resistive sensor reader.
package brsr_pkg;

  localparam int unsigned SMP_W = 10;   // converter sample width
  localparam int unsigned KR_W  = 16;   // known resistor width
  localparam int unsigned RES_W = 27;   // one resistance reading
  localparam int unsigned AVG_W = 28;   // phase average and bias
  localparam int unsigned SUM_W = 32;   // phase sum
  localparam int unsigned PRD_W = 28;   // resistor times difference
  localparam int unsigned DIV_W = 31;   // divider dividend magnitude

  localparam logic [KR_W-1:0]         KR_RESET  = 16'd4700;
  localparam logic signed [RES_W-1:0] RES_LIMIT = 27'sd67043025;

  typedef struct packed {
    logic load_in;      // capture input samples
    logic mul;          // register resistor times difference
    logic res_sat;      // zero sensor sample: saturate and flag
    logic div_res;      // start divide: product by sensor sample
    logic div_avg;      // start divide: phase sum by read count
    logic res_take;     // take signed quotient as reading
    logic acc;          // add reading to phase sum
    logic cnt_inc;      // advance reading count
    logic first_store;  // store first phase average, clear sum
    logic out_load;     // load result register, clear cycle state
  } brsr_cmd_t;

  typedef struct packed {
    logic sensor_zero;
    logic div_done;
    logic phase_last;
    logic cycle_last;
    logic out_free;
  } brsr_sts_t;

endpackage

@@ rtl/bipolar_resistive_sensor_reader_unit.sv @@
// Top level of the bipolar resistive sensor reader.
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata: supply_sample, sensor_sample
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata: compensated_resistance,
//                                              polarity_bias; tuser: zero flag
//  cfg      in   cfg_we_i                      cfg_wdata_i: known_resistor
//
// Each request loads the samples, registers the product and divides it by the sensor sample
// in the 31-step shared divider (a zero sensor sample saturates instead); the last request
// of each phase also divides the phase sum for the average, and the second phase then loads the result.
// One request is worked at a time; the result register holds a finished result
// while the next requests are taken, and a new result waits until it is free.
// Reset clears the sums, count and flag and loads the resistor with 4700.
module bipolar_resistive_sensor_reader_unit import brsr_pkg::*; #(
  parameter int unsigned READS = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [KR_W-1:0] cfg_wdata_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [23:0]     s_axis_tdata,   // [9:0] supply_sample, [19:10] sensor_sample
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [55:0]     m_axis_tdata,   // [26:0] compensated_resistance, [54:27] polarity_bias
  output logic            m_axis_tuser    // [0] zero_divisor_seen
);

  brsr_cmd_t cmd;
  brsr_sts_t sts;

  brsr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  brsr_dp #(.READS(READS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

@@ rtl/brsr_div.sv @@
// Sequential restoring divider, one quotient bit per cycle.
module brsr_div import brsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [SMP_W-1:0] divisor_i,
  output logic [DIV_W-1:0] quotient_o,
  output logic             done_o
);

  localparam int unsigned CntW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_q;
  logic [SMP_W-1:0] rem_q;
  logic [SMP_W-1:0] dvs_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [SMP_W+1:0] trial;

  assign trial = {1'b0, rem_q, quo_q[DIV_W-1]} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(DIV_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[SMP_W+1]) begin
        rem_q <= trial[SMP_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[SMP_W-2:0], quo_q[DIV_W-1]};
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

@@ rtl/brsr_dp.sv @@
// Datapath: samples, product, divider, phase sum, averages and result register.
module brsr_dp import brsr_pkg::*; #(
  parameter int unsigned READS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [KR_W-1:0]       cfg_wdata_i,
  input  logic [23:0]           s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [55:0]           m_axis_tdata,
  output logic                  m_axis_tuser,
  input  brsr_cmd_t             cmd_i,
  output brsr_sts_t             sts_o
);

  localparam int unsigned CntW = $clog2(2 * READS);

  logic [KR_W-1:0]          kr_q;
  logic [SMP_W-1:0]         sup_q, sen_q;
  logic signed [PRD_W-1:0]  prod_q;
  logic signed [RES_W-1:0]  res_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [AVG_W-1:0]  first_q;
  logic [CntW-1:0]          cnt_q;
  logic                     sticky_q;
  logic                     neg_q;
  logic                     vld_q;
  logic [RES_W-1:0]         comp_q;
  logic [AVG_W-1:0]         bias_q;
  logic                     flag_q;

  logic signed [SMP_W:0]    diff;
  logic signed [PRD_W-1:0]  prod_abs;
  logic signed [SUM_W-1:0]  sum_abs;
  logic                     div_start;
  logic [DIV_W-1:0]         div_a;
  logic [SMP_W-1:0]         div_b;
  logic [DIV_W-1:0]         quo;
  logic                     div_done;
  logic signed [SUM_W-1:0]  quo_s, div_val;
  logic signed [AVG_W-1:0]  second;
  logic signed [AVG_W:0]    pair_sum;
  logic [AVG_W:0]           pair_rnd;
  logic [CntW:0]            cnt_next;

  assign diff     = $signed({1'b0, sup_q}) - $signed({1'b0, sen_q});
  assign prod_abs = prod_q[PRD_W-1] ? -prod_q : prod_q;
  assign sum_abs  = sum_q[SUM_W-1] ? -sum_q : sum_q;

  assign div_start = cmd_i.div_res | cmd_i.div_avg;
  assign div_a = cmd_i.div_avg ? sum_abs[DIV_W-1:0] : DIV_W'(unsigned'(prod_abs));
  assign div_b = cmd_i.div_avg ? SMP_W'(READS) : sen_q;

  brsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  assign quo_s   = $signed({1'b0, quo});
  assign div_val = neg_q ? -quo_s : quo_s;
  assign second  = div_val[AVG_W-1:0];

  // mean of both phases, truncated toward zero
  assign pair_sum = (AVG_W+1)'(first_q) + (AVG_W+1)'(second);
  assign pair_rnd = pair_sum + (AVG_W+1)'(pair_sum[AVG_W]);

  assign cnt_next = (CntW+1)'(cnt_q) + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kr_q     <= KR_RESET;
      sum_q    <= '0;
      cnt_q    <= '0;
      first_q  <= '0;
      sticky_q <= 1'b0;
      vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) kr_q <= cfg_wdata_i;
      if (cmd_i.res_sat) sticky_q <= 1'b1;
      if (cmd_i.acc) sum_q <= sum_q + SUM_W'(res_q);
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.first_store) begin
        first_q <= div_val[AVG_W-1:0];
        sum_q   <= '0;
        cnt_q   <= cnt_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        sum_q    <= '0;
        cnt_q    <= '0;
        sticky_q <= 1'b0;
        vld_q    <= 1'b1;
      end else if (m_axis_tready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sup_q <= s_axis_tdata[SMP_W-1:0];
      sen_q <= s_axis_tdata[2*SMP_W-1:SMP_W];
    end
    if (cmd_i.mul) prod_q <= $signed({1'b0, kr_q}) * diff;
    if (div_start) neg_q <= cmd_i.div_avg ? sum_q[SUM_W-1] : prod_q[PRD_W-1];
    if (cmd_i.res_sat) res_q <= RES_LIMIT;
    else if (cmd_i.res_take) res_q <= div_val[RES_W-1:0];
    if (cmd_i.out_load) begin
      comp_q <= pair_rnd[RES_W:1];
      bias_q <= first_q - second;
      flag_q <= sticky_q;
    end
  end

  assign sts_o.sensor_zero = (sen_q == '0);
  assign sts_o.div_done    = div_done;
  assign sts_o.phase_last  = (cnt_next == (CntW+1)'(READS));
  assign sts_o.cycle_last  = (cnt_next >= (CntW+1)'(2 * READS));
  assign sts_o.out_free    = !vld_q || m_axis_tready;

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {1'b0, bias_q, comp_q};
  assign m_axis_tuser  = flag_q;

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!vld_q || m_axis_tready))
    else $error("result loaded over a waiting result");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CntW+1)'(cnt_q) < (CntW+1)'(2 * READS))
    else $error("reading count out of range");

  a_out_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (cnt_q == '0 && sum_q == '0 && !sticky_q && vld_q))
    else $error("cycle state not cleared after result");

endmodule

@@ rtl/brsr_ctrl.sv @@
// Controller: sequences one reading and the phase averages through the datapath.
module brsr_ctrl import brsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  brsr_sts_t sts_i,
  output brsr_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_RSTART = 4'd2;
  localparam logic [3:0] S_RDIV   = 4'd3;
  localparam logic [3:0] S_ACC    = 4'd4;
  localparam logic [3:0] S_AVG    = 4'd5;
  localparam logic [3:0] S_ADIV   = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load_in = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_RSTART;
      end
      S_RSTART: begin
        if (sts_i.sensor_zero) begin
          cmd_o.res_sat = 1'b1;
          state_d = S_ACC;
        end else begin
          cmd_o.div_res = 1'b1;
          state_d = S_RDIV;
        end
      end
      S_RDIV: begin
        if (sts_i.div_done) begin
          cmd_o.res_take = 1'b1;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        if (sts_i.phase_last || sts_i.cycle_last) begin
          state_d = S_AVG;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_AVG: begin
        cmd_o.div_avg = 1'b1;
        state_d = S_ADIV;
      end
      S_ADIV: begin
        if (sts_i.div_done) begin
          if (sts_i.phase_last) begin
            cmd_o.first_store = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RSTART && !sts_i.sensor_zero) |=> state_q == S_RDIV)
    else $error("divider started without waiting");

  a_single_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.div_res && cmd_o.div_avg))
    else $error("two divider requests at once");

  a_first_vs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.first_store && cmd_o.out_load))
    else $error("first average stored with result");

endmodule

@@ tb/tb_top.sv @@
// Testbench for the bipolar resistive sensor reader, checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import brsr_pkg::*;

  localparam int READS      = 10;
  localparam int HOLD_LEN   = 3000;
  localparam int SETTLE_LEN = 120;
  localparam int CYCLE_MAX  = 600000;

  typedef struct packed {
    logic [SMP_W-1:0] supply;
    logic [SMP_W-1:0] sensor;
  } sample_pair_t;

  typedef struct packed {
    logic [RES_W-1:0] comp;
    logic [AVG_W-1:0] bias;
    logic             zero_seen;
  } ohm_result_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [KR_W-1:0] cfg_wdata_i;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [23:0]     s_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [55:0]     m_axis_tdata;
  logic            m_axis_tuser;

  sample_pair_t pairs_waiting[$];
  ohm_result_t  results_due[$];

  // predictor state
  logic [KR_W-1:0] kr_ohms;
  int              phase_sum;
  int              reads_done;
  int              first_avg;
  bit              zero_sticky;

  bit pair_taken;
  bit calm;
  bit hold_go;
  bit hold_used;
  int hold_left;
  int error_count;
  int cycle_count;

  bipolar_resistive_sensor_reader_unit #(
    .READS(READS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic take_reading(input logic [SMP_W-1:0] sup, input logic [SMP_W-1:0] sen);
    longint      diff;
    longint      ohms;
    int          second_avg;
    int          comp;
    int          bias;
    ohm_result_t res;
    if (sen == '0) begin
      zero_sticky = 1'b1;
      ohms = longint'(RES_LIMIT);
    end else begin
      diff = longint'(sup) - longint'(sen);
      ohms = (longint'(kr_ohms) * diff) / longint'(sen);
    end
    phase_sum = phase_sum + int'(ohms);
    if (reads_done + 1 == READS) begin
      first_avg  = phase_sum / READS;
      phase_sum  = 0;
      reads_done = reads_done + 1;
    end else if (reads_done + 1 >= 2 * READS) begin
      second_avg    = phase_sum / READS;
      comp          = (first_avg + second_avg) / 2;
      bias          = first_avg - second_avg;
      res.comp      = comp[RES_W-1:0];
      res.bias      = bias[AVG_W-1:0];
      res.zero_seen = zero_sticky;
      results_due.push_back(res);
      phase_sum   = 0;
      reads_done  = 0;
      zero_sticky = 1'b0;
    end else begin
      reads_done = reads_done + 1;
    end
  endtask

  // input side: register writes and accepted requests
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) kr_ohms = cfg_wdata_i;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      take_reading(s_axis_tdata[9:0], s_axis_tdata[19:10]);
      pair_taken = 1'b1;
    end
  end

  // output side
  always @(posedge clk_i) begin
    ohm_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result comp %h bias %h zero %b", $time,
                 m_axis_tdata[26:0], m_axis_tdata[54:27], m_axis_tuser);
        error_count++;
      end else begin
        want = results_due.pop_front();
        if (m_axis_tdata[26:0] !== want.comp) begin
          $display("%0t: comp expected %h actual %h", $time, want.comp, m_axis_tdata[26:0]);
          error_count++;
        end
        if (m_axis_tdata[54:27] !== want.bias) begin
          $display("%0t: bias expected %h actual %h", $time, want.bias, m_axis_tdata[54:27]);
          error_count++;
        end
        if (m_axis_tuser !== want.zero_seen) begin
          $display("%0t: zero flag expected %b actual %b", $time, want.zero_seen, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    sample_pair_t p;
    if (rst_ni && (!s_axis_tvalid || pair_taken)) begin
      pair_taken = 1'b0;
      if (pairs_waiting.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
        p = pairs_waiting.pop_front();
        s_axis_tdata  <= {4'b0, p.sensor, p.supply};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_left = HOLD_LEN;
      hold_used = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_MAX) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic push_pair(input int sup, input int sen);
    sample_pair_t p;
    p.supply = sup[SMP_W-1:0];
    p.sensor = sen[SMP_W-1:0];
    pairs_waiting.push_back(p);
  endtask

  task automatic push_random(input int count);
    int sel;
    int sup;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      sup = $urandom_range(1023);
      if (sel < 4) push_pair(sup, 0);
      else if (sel < 10) push_pair(sup, sup);
      else if (sel < 28) push_pair(sup, $urandom_range(15, 1));
      else if (sel < 38) push_pair(sup, 1023);
      else if (sel < 45) push_pair($urandom_range(7), $urandom_range(1023, 1000));
      else push_pair(sup, $urandom_range(1023));
    end
  endtask

  task automatic write_kr(input logic [KR_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic drain;
    while (pairs_waiting.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_LEN) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    kr_ohms       = KR_RESET;
    phase_sum     = 0;
    reads_done    = 0;
    first_avg     = 0;
    zero_sticky   = 1'b0;
    pair_taken    = 1'b0;
    calm          = 1'b0;
    hold_go       = 1'b0;
    hold_used     = 1'b0;
    hold_left     = 0;
    error_count   = 0;
    cycle_count   = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes and zero sensor under the reset resistor
    push_pair(0, 0);
    push_pair(1023, 0);
    push_pair(1023, 1023);
    push_pair(1023, 1);
    push_pair(0, 1);
    push_pair(0, 1023);
    push_pair(682, 341);
    push_pair(341, 682);
    push_pair(512, 512);
    push_pair(1, 1);
    push_pair(1023, 1);
    push_pair(1023, 1);
    push_pair(0, 1);
    push_pair(0, 1);
    push_pair(0, 1023);
    push_pair(1022, 511);
    push_pair(1, 1022);
    push_pair(1023, 2);
    push_pair(100, 3);
    push_pair(5, 1000);
    push_pair(1023, 0);
    push_pair(0, 0);
    push_pair(300, 700);
    drain();

    write_kr(16'hFFFF);
    push_pair(1023, 1);
    push_pair(0, 1);
    push_pair(0, 1023);
    push_random(200);
    drain();

    // receiver holds off while requests keep coming
    write_kr(KR_W'($urandom_range(65535, 1)));
    hold_go = 1'b1;
    push_random(230);
    drain();

    write_kr('0);
    push_random(97);
    drain();

    write_kr(16'd1);
    calm = 1'b1;
    push_random(151);
    drain();
    calm = 1'b0;

    for (int k = 0; k < 3; k++) begin
      write_kr(KR_W'($urandom_range(65535)));
      push_random($urandom_range(140, 100));
      drain();
    end

    write_kr(KR_RESET);
    push_random(149);
    drain();

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/brsr_pkg.sv
rtl/brsr_div.sv
rtl/brsr_dp.sv
rtl/brsr_ctrl.sv
rtl/bipolar_resistive_sensor_reader_unit.sv
tb/tb_top.sv
